>>> hw/rtl/linear_probe_hash_table_top_macros.svh
// Assertion macros shared by the hash table RTL.
`ifndef LINEAR_PROBE_HASH_TABLE_TOP_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_TOP_MACROS_SVH

`ifndef SYNTH
// Check that a condition holds at every clock edge out of reset.
`define LPHT_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Check that a condition implies another in the same cycle.
`define LPHT_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define LPHT_ASSERT_ALWAYS(lbl, clk, rst, cond, msg)
`define LPHT_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`endif

`endif

>>> hw/rtl/lpht_pkg.sv
// Shared constants, types and helper functions of the hash table.
package lpht_pkg;

  localparam int CAPACITY   = 1024;
  localparam int IDX_W      = 10;
  localparam int SIZE_W     = 11;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int HASH_BITS  = 32;
  localparam int STEP_W     = 5;

  localparam logic [SIZE_W-1:0] INIT_SIZE_RST = 11'd33;
  localparam logic [SIZE_W-1:0] CAP_SIZE      = 11'd1024;
  localparam logic [IDX_W-1:0]  IDX_LAST      = 10'd1023;

  // operation codes
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_DUP    = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [HASH_BITS-1:0]  hash_t;

  typedef struct packed {
    key_t   key;
    value_t value;
    hash_t  hash;
  } ent_t;

  typedef struct packed {
    logic [1:0] opcode;
    key_t       key;
    hash_t      key_hash;
    value_t     value;
  } item_t;

  typedef struct packed {
    logic              found;
    value_t            value_out;
    logic [1:0]        status;
    logic [SIZE_W-1:0] entry_count;
  } res_t;

  typedef struct packed {
    logic              wr;
    logic [SIZE_W-1:0] wr_size;
    logic [SIZE_W-1:0] floor_size;
  } cfg_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } ctrl_stat_t;

  typedef struct packed {
    logic              start;
    hash_t             dividend;
    logic [SIZE_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic              done;
    logic [SIZE_W-1:0] rem;
  } mod_rsp_t;

  // Clamp a written table size into 1..CAPACITY.
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) r = 11'd1;
    else if (v > CAP_SIZE) r = CAP_SIZE;
    return r;
  endfunction

  // floor(x/3) for x up to 2048: reciprocal 2731 / 2^13.
  function automatic logic [SIZE_W-1:0] div3_floor(input logic [SIZE_W:0] x);
    logic [25:0] p;
    p = {14'd0, x} * 26'd2731;
    return p[23:13];
  endfunction

  // floor(x/5) for x up to 1024: reciprocal 1639 / 2^13.
  function automatic logic [SIZE_W-1:0] div5_floor(input logic [SIZE_W-1:0] x);
    logic [21:0] p;
    p = {11'd0, x} * 22'd1639;
    return {2'd0, p[21:13]};
  endfunction

  // Next probe slot with wrap at the size in use.
  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i,
                                                input logic [SIZE_W-1:0] sz);
    logic [SIZE_W-1:0] inc;
    inc = {1'b0, i} + 11'd1;
    return (inc >= sz) ? '0 : inc[IDX_W-1:0];
  endfunction

endpackage

>>> hw/rtl/lpht_if.sv
// Valid/ready channel interfaces for operation and result words.
interface lpht_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] key;
  logic [31:0] key_hash;
  logic [31:0] value;
  modport source (output valid, opcode, key, key_hash, value, input ready);
  modport sink   (input valid, opcode, key, key_hash, value, output ready);
endinterface

interface lpht_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] value_out;
  logic [1:0]  status;
  logic [10:0] entry_count_out;
  modport source (output valid, found, value_out, status, entry_count_out, input ready);
  modport sink   (input valid, found, value_out, status, entry_count_out, output ready);
endinterface

>>> hw/rtl/lpht_mod_unit.sv
// Bit-serial remainder unit: hash modulo table size, one quotient bit a cycle.
module lpht_mod_unit (
  input  logic              clk,
  input  logic              rst,
  input  lpht_pkg::mod_req_t req,
  output lpht_pkg::mod_rsp_t rsp
);
  import lpht_pkg::*;

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] cnt;
  hash_t             acc;
  logic [SIZE_W-1:0] rem;
  logic [SIZE_W-1:0] div;
  logic [SIZE_W:0]   trial;

  // shift in the next dividend bit
  assign trial = {rem, acc[HASH_BITS-1]};

  // step the restoring remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        acc  <= req.dividend;
        rem  <= '0;
        div  <= req.divisor;
      end else if (busy) begin
        acc <= acc << 1;
        if (trial >= {1'b0, div}) rem <= SIZE_W'(trial - {1'b0, div});
        else rem <= trial[SIZE_W-1:0];
        cnt <= cnt + 1'b1;
        if (cnt == STEP_W'(HASH_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule

>>> hw/rtl/lpht_ctrl.sv
// Table memories and the sequencer for probe, place, rehash and cluster repair.
`include "linear_probe_hash_table_top_macros.svh"
module lpht_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  lpht_pkg::cfg_t       cfg,
  input  lpht_pkg::item_t      item,
  input  logic                 start,
  input  logic                 res_ready,
  output lpht_pkg::res_t       res,
  output lpht_pkg::ctrl_stat_t stat,
  output lpht_pkg::mod_req_t   mod_req,
  input  lpht_pkg::mod_rsp_t   mod_rsp
);
  import lpht_pkg::*;

  localparam logic [4:0] S_CLEAR    = 5'd0;
  localparam logic [4:0] S_IDLE     = 5'd1;
  localparam logic [4:0] S_PR_START = 5'd2;
  localparam logic [4:0] S_PR_DIV   = 5'd3;
  localparam logic [4:0] S_PR_WAIT  = 5'd4;
  localparam logic [4:0] S_PR_EVAL  = 5'd5;
  localparam logic [4:0] S_DECIDE   = 5'd6;
  localparam logic [4:0] S_RH_WAIT  = 5'd7;
  localparam logic [4:0] S_RH_EVAL  = 5'd8;
  localparam logic [4:0] S_RH_PLACE = 5'd9;
  localparam logic [4:0] S_RH_TMP   = 5'd10;
  localparam logic [4:0] S_PL_START = 5'd11;
  localparam logic [4:0] S_PL_DIV   = 5'd12;
  localparam logic [4:0] S_PL_WAIT  = 5'd13;
  localparam logic [4:0] S_PL_EVAL  = 5'd14;
  localparam logic [4:0] S_RM_CLR   = 5'd15;
  localparam logic [4:0] S_WK_STEP  = 5'd16;
  localparam logic [4:0] S_WK_WAIT  = 5'd17;
  localparam logic [4:0] S_WK_EVAL  = 5'd18;
  localparam logic [4:0] S_FINISH   = 5'd19;
  localparam logic [4:0] S_PL_DONE  = 5'd20;

  localparam logic       PR_RET_OP  = 1'b0;
  localparam logic       PR_RET_REM = 1'b1;
  localparam logic       RH_RET_INS = 1'b0;
  localparam logic       RH_RET_REM = 1'b1;
  localparam logic [1:0] PL_RET_RH   = 2'd0;
  localparam logic [1:0] PL_RET_INS  = 2'd1;
  localparam logic [1:0] PL_RET_WALK = 2'd2;

  logic [4:0]        state;
  logic [SIZE_W-1:0] size;
  logic [SIZE_W-1:0] count;
  logic [1:0]        op;
  key_t              key;
  hash_t             hash;
  value_t            val;
  ent_t              pent;
  logic [IDX_W-1:0]  slot;
  logic [IDX_W-1:0]  at;
  logic [IDX_W-1:0]  walk_i;
  logic [SIZE_W-1:0] steps;
  logic [SIZE_W-1:0] walk_n;
  logic [SIZE_W-1:0] ns;
  logic [SIZE_W-1:0] tmp_n;
  logic [SIZE_W-1:0] tmp_i;
  logic              hit;
  logic              found;
  value_t            vout;
  logic [1:0]        status;
  logic              pr_ret;
  logic              rh_ret;
  logic [1:0]        pl_ret;
  logic              pl_ok;

  // table storage
  logic used_mem [CAPACITY];
  ent_t ent_mem  [CAPACITY];
  ent_t tmp_mem  [CAPACITY];
  logic used_q;
  ent_t ent_q;
  ent_t tmp_q;

  logic             used_we;
  logic             used_wd;
  logic [IDX_W-1:0] used_wa;
  logic             ent_we;
  logic             tmp_we;

  logic [SIZE_W-1:0] slot_ext;
  logic [IDX_W-1:0]  slot_nx;
  logic [IDX_W-1:0]  walk_nx;
  logic [SIZE_W:0]   grow_raw;
  logic [SIZE_W-1:0] grow_ns;
  logic              need_grow;
  logic              need_shrink;

  assign slot_ext = {1'b0, slot};
  assign slot_nx  = next_idx(slot, size);
  assign walk_nx  = next_idx(walk_i, size);

  // resize decisions
  assign grow_raw    = {size, 1'b1};
  assign grow_ns     = (grow_raw > {1'b0, CAP_SIZE}) ? CAP_SIZE : grow_raw[SIZE_W-1:0];
  assign need_grow   = ({1'b0, count} + 12'd1) > {1'b0, div3_floor({size, 1'b0})};
  assign need_shrink = ((count - 11'd1) < div5_floor(size)) && (size > cfg.floor_size);

  // drive the shared modulo unit
  assign mod_req.start    = (state == S_PR_START) || (state == S_PL_START);
  assign mod_req.dividend = (state == S_PL_START) ? pent.hash : hash;
  assign mod_req.divisor  = size;

  // select memory writes
  always_comb begin
    used_we = 1'b0;
    used_wd = 1'b0;
    used_wa = slot;
    ent_we  = 1'b0;
    tmp_we  = 1'b0;
    case (state)
      S_CLEAR: used_we = 1'b1;
      S_RH_EVAL: begin
        used_we = 1'b1;
        tmp_we  = used_q;
      end
      S_PL_EVAL: begin
        if (steps != size && !used_q) begin
          used_we = 1'b1;
          used_wd = 1'b1;
          ent_we  = 1'b1;
        end
      end
      S_RM_CLR: begin
        used_we = 1'b1;
        used_wa = at;
      end
      S_WK_EVAL: used_we = used_q;
      default: used_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (used_we) used_mem[used_wa] <= used_wd;
    used_q <= used_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[slot] <= pent;
    ent_q <= ent_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (tmp_we) tmp_mem[tmp_n[IDX_W-1:0]] <= ent_q;
    tmp_q <= tmp_mem[tmp_i[IDX_W-1:0]];
  end

  // sequence one operation
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      size  <= INIT_SIZE_RST;
      count <= '0;
      slot  <= '0;
    end else if (cfg.wr) begin
      state <= S_CLEAR;
      size  <= cfg.wr_size;
      count <= '0;
      slot  <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          slot <= slot + 1'b1;
          if (slot == IDX_LAST) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            op     <= item.opcode;
            key    <= item.key;
            hash   <= item.key_hash;
            val    <= item.value;
            pr_ret <= PR_RET_OP;
            found  <= 1'b0;
            vout   <= '0;
            status <= ST_OK;
            state  <= S_PR_START;
          end
        end
        S_PR_START: state <= S_PR_DIV;
        S_PR_DIV: begin
          if (mod_rsp.done) begin
            slot  <= mod_rsp.rem[IDX_W-1:0];
            steps <= '0;
            state <= S_PR_WAIT;
          end
        end
        S_PR_WAIT: state <= S_PR_EVAL;
        S_PR_EVAL: begin
          if (steps == size || !used_q) begin
            hit   <= 1'b0;
            state <= S_DECIDE;
          end else if (ent_q.key == key) begin
            hit   <= 1'b1;
            at    <= slot;
            state <= S_DECIDE;
          end else begin
            slot  <= slot_nx;
            steps <= steps + 1'b1;
            state <= S_PR_WAIT;
          end
        end
        S_DECIDE: begin
          if (pr_ret == PR_RET_REM) begin
            state <= hit ? S_RM_CLR : S_FINISH;
          end else begin
            case (op)
              OP_LOOKUP: begin
                if (hit) begin
                  found <= 1'b1;
                  vout  <= ent_q.value;
                end
                state <= S_FINISH;
              end
              OP_INSERT: begin
                pent <= '{key: key, value: val, hash: hash};
                if (hit) begin
                  found  <= 1'b1;
                  status <= ST_DUP;
                  state  <= S_FINISH;
                end else if (need_grow && grow_ns != size) begin
                  ns     <= grow_ns;
                  rh_ret <= RH_RET_INS;
                  slot   <= '0;
                  tmp_n  <= '0;
                  state  <= S_RH_WAIT;
                end else begin
                  pl_ret <= PL_RET_INS;
                  state  <= S_PL_START;
                end
              end
              OP_REMOVE: begin
                if (!hit) begin
                  status <= ST_ABSENT;
                  state  <= S_FINISH;
                end else begin
                  found <= 1'b1;
                  if (need_shrink) begin
                    ns     <= size >> 1;
                    rh_ret <= RH_RET_REM;
                    slot   <= '0;
                    tmp_n  <= '0;
                    state  <= S_RH_WAIT;
                  end else begin
                    state <= S_RM_CLR;
                  end
                end
              end
              default: state <= S_FINISH;
            endcase
          end
        end
        S_RH_WAIT: state <= S_RH_EVAL;
        S_RH_EVAL: begin
          if (used_q) tmp_n <= tmp_n + 1'b1;
          if (slot_ext == size - 11'd1) begin
            size  <= ns;
            count <= '0;
            tmp_i <= '0;
            state <= S_RH_PLACE;
          end else begin
            slot  <= slot + 1'b1;
            state <= S_RH_WAIT;
          end
        end
        S_RH_PLACE: begin
          if (tmp_i == tmp_n) begin
            if (rh_ret == RH_RET_INS) begin
              // restore the new entry, the moves have reused the place word
              pent   <= '{key: key, value: val, hash: hash};
              pl_ret <= PL_RET_INS;
              state  <= S_PL_START;
            end else begin
              pr_ret <= PR_RET_REM;
              state  <= S_PR_START;
            end
          end else begin
            state <= S_RH_TMP;
          end
        end
        S_RH_TMP: begin
          pent   <= tmp_q;
          tmp_i  <= tmp_i + 1'b1;
          pl_ret <= PL_RET_RH;
          state  <= S_PL_START;
        end
        S_PL_START: state <= S_PL_DIV;
        S_PL_DIV: begin
          if (mod_rsp.done) begin
            slot  <= mod_rsp.rem[IDX_W-1:0];
            steps <= '0;
            state <= S_PL_WAIT;
          end
        end
        S_PL_WAIT: state <= S_PL_EVAL;
        S_PL_EVAL: begin
          if (steps == size) begin
            pl_ok <= 1'b0;
            state <= S_PL_DONE;
          end else if (!used_q) begin
            count <= count + 1'b1;
            pl_ok <= 1'b1;
            state <= S_PL_DONE;
          end else begin
            slot  <= slot_nx;
            steps <= steps + 1'b1;
            state <= S_PL_WAIT;
          end
        end
        S_PL_DONE: begin
          case (pl_ret)
            PL_RET_RH: state <= S_RH_PLACE;
            PL_RET_INS: begin
              status <= pl_ok ? ST_OK : ST_FULL;
              state  <= S_FINISH;
            end
            PL_RET_WALK: state <= S_WK_STEP;
            default: state <= S_FINISH;
          endcase
        end
        S_RM_CLR: begin
          count  <= count - 1'b1;
          walk_n <= 11'd1;
          walk_i <= at;
          state  <= S_WK_STEP;
        end
        S_WK_STEP: begin
          if (walk_n >= size) begin
            state <= S_FINISH;
          end else begin
            slot   <= walk_nx;
            walk_i <= walk_nx;
            state  <= S_WK_WAIT;
          end
        end
        S_WK_WAIT: state <= S_WK_EVAL;
        S_WK_EVAL: begin
          if (!used_q) begin
            state <= S_FINISH;
          end else begin
            pent   <= ent_q;
            count  <= count - 1'b1;
            walk_n <= walk_n + 1'b1;
            pl_ret <= PL_RET_WALK;
            state  <= S_PL_START;
          end
        end
        S_FINISH: begin
          if (res_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign stat.idle      = (state == S_IDLE);
  assign stat.res_valid = (state == S_FINISH);

  assign res.found       = found;
  assign res.value_out   = vout;
  assign res.status      = status;
  assign res.entry_count = count;

  `LPHT_ASSERT_ALWAYS(a_count_fits, clk, rst, count <= size, "entry count above table size")
  `LPHT_ASSERT_IMPLIES(a_mod_done_waited, clk, rst, mod_rsp.done, (state == S_PR_DIV) || (state == S_PL_DIV), "modulo result with no waiter")
  `LPHT_ASSERT_IMPLIES(a_slot_in_range, clk, rst, (state == S_PR_EVAL) || (state == S_PL_EVAL), slot_ext < size, "probe slot outside table")

endmodule

>>> hw/rtl/linear_probe_hash_table_top.sv
// Open-addressing hash table with linear probing: top level.
// Each word runs alone: start, serial modulo, then a wait and an evaluate state per probed slot;
// a lookup then ends in the finish state, and the next word is taken once it is back in idle.
// An insert adds a place pass; a rehash visits every old slot, then places each moved entry.
// Reset and each initial_size write run an occupancy clearing pass over all 1024 slots, no word taken.
// The result register lets a finished result wait while the next word is worked on.
module linear_probe_hash_table_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,
  lpht_in_if.sink     in_ch,
  lpht_out_if.source  out_ch
);
  import lpht_pkg::*;

  logic [SIZE_W-1:0] init_size;
  cfg_t              cfg;
  item_t             item;
  res_t              res;
  ctrl_stat_t        stat;
  mod_req_t          mod_req;
  mod_rsp_t          mod_rsp;
  logic              res_ready;
  logic              out_valid;
  res_t              out_res;

  // hold the clamped size floor
  always_ff @(posedge clk) begin
    if (rst) init_size <= INIT_SIZE_RST;
    else if (cfg_we) init_size <= clamp_size(cfg_wdata);
  end

  assign cfg.wr         = cfg_we;
  assign cfg.wr_size    = clamp_size(cfg_wdata);
  assign cfg.floor_size = init_size;

  assign item.opcode   = in_ch.opcode;
  assign item.key      = in_ch.key;
  assign item.key_hash = in_ch.key_hash;
  assign item.value    = in_ch.value;
  assign in_ch.ready   = stat.idle;

  assign res_ready = !out_valid || out_ch.ready;

  lpht_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item      (item),
    .start     (in_ch.valid && stat.idle),
    .res_ready (res_ready),
    .res       (res),
    .stat      (stat),
    .mod_req   (mod_req),
    .mod_rsp   (mod_rsp)
  );

  lpht_mod_unit u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  // load the result word, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stat.res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.res_valid && res_ready) out_res <= res;
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.found           = out_res.found;
  assign out_ch.value_out       = out_res.value_out;
  assign out_ch.status          = out_res.status;
  assign out_ch.entry_count_out = out_res.entry_count;

endmodule
